/* rtl/sprlm_pkg.sv */
// Shared types, constants and helpers of the stereo peak/RMS level meter.
`default_nettype none
package sprlm_pkg;

	localparam int MAG_W    = 16;          // sample magnitude, 0..32768
	localparam int RAD_W    = 2 * MAG_W;   // isqrt radicand
	localparam int REM_W    = MAG_W + 1;   // isqrt partial remainder
	localparam int SQ_STEPS = MAG_W;       // one root bit per step
	localparam int SSTEP_W  = $clog2(SQ_STEPS);
	localparam int FCNT_W   = 13;          // frames_counted field

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_STEREO_MODE = 1'b0;

	typedef struct packed {
		logic signed [15:0] l_smp;
		logic signed [15:0] r_smp;
		logic               last_in_block;
	} in_beat_t;

	typedef struct packed {
		logic [15:0]       l_lvl;
		logic [15:0]       r_lvl;
		logic [15:0]       overall_peak;
		logic [15:0]       mean_level;
		logic [FCNT_W-1:0] frames_counted;
		logic              block_overflow;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic acc_en;
		logic div_load;
		logic div_step;
		logic sq_load;
		logic sq_step;
		logic finish;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_last;
		logic sq_last;
	} ctrl_sts_t;

	// |s| of a 16-bit two's complement sample; -32768 maps to 0x8000
	function automatic logic [MAG_W-1:0] mag16(input logic signed [15:0] s);
		logic [MAG_W-1:0] r;
		if (s[15]) begin
			r = ~s + 16'd1;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/sprlm_ctrl.sv */
// Sequencer: accumulate, divide, square root, then load the result register.
`default_nettype none
module sprlm_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_last,
	input  wire logic                  out_stall,
	input  wire sprlm_pkg::ctrl_sts_t  sts,
	output logic                       in_stall,
	output logic                       out_valid,
	output sprlm_pkg::ctrl_cmd_t       cmd
);

	typedef enum logic [5:0] {
		ST_ACC   = 6'b000001,
		ST_DINIT = 6'b000010,
		ST_DRUN  = 6'b000100,
		ST_SINIT = 6'b001000,
		ST_SRUN  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_take;
	logic   can_load;

	assign in_stall  = (state_q != ST_ACC);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	// result register is free or is being emptied this cycle
	assign can_load  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_ACC: begin
				cmd.acc_en = in_take;
				if (in_take && in_last) begin
					state_d = ST_DINIT;
				end
			end
			ST_DINIT: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DRUN;
			end
			ST_DRUN: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SINIT;
				end
			end
			ST_SINIT: begin
				cmd.sq_load = 1'b1;
				state_d     = ST_SRUN;
			end
			ST_SRUN: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (can_load) begin
					cmd.finish = 1'b1;
					state_d    = ST_ACC;
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/sprlm_dp.sv */
// Datapath: per-channel accumulators, bit-serial divider and isqrt, result register.
`default_nettype none
module sprlm_dp #(
	parameter int MAX_FRAMES = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sprlm_pkg::ctrl_cmd_t  cmd,
	input  wire logic                  stereo_mode,
	input  wire sprlm_pkg::in_beat_t   in_data,
	output sprlm_pkg::ctrl_sts_t       sts,
	output sprlm_pkg::out_beat_t       out_data
);

	localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
	// a square is at most 2^30, so MAX_FRAMES of them fit here
	localparam int SUM_W   = $clog2(MAX_FRAMES) + 31;
	localparam int DSTEP_W = $clog2(SUM_W);
	localparam int MAG_W   = sprlm_pkg::MAG_W;
	localparam int RAD_W   = sprlm_pkg::RAD_W;
	localparam int REM_W   = sprlm_pkg::REM_W;
	localparam int SSTEP_W = sprlm_pkg::SSTEP_W;
	localparam int FCNT_W  = sprlm_pkg::FCNT_W;

	// ---------------- accumulation ----------------
	logic [MAG_W-1:0]   lmag, rmag;
	logic [RAD_W-1:0]   lsq, rsq;
	logic [SUM_W-1:0]   lsum_q, rsum_q;
	logic [MAG_W-1:0]   lpeak_q, rpeak_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               ovf_q;
	logic               cnt_full;

	assign lmag     = sprlm_pkg::mag16(in_data.l_smp);
	assign rmag     = stereo_mode ? sprlm_pkg::mag16(in_data.r_smp) : lmag;
	assign lsq      = RAD_W'(lmag) * RAD_W'(lmag);
	assign rsq      = RAD_W'(rmag) * RAD_W'(rmag);
	assign cnt_full = (cnt_q == CNT_W'(MAX_FRAMES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsum_q  <= '0;
			rsum_q  <= '0;
			lpeak_q <= '0;
			rpeak_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.finish) begin
			lsum_q  <= '0;
			rsum_q  <= '0;
			lpeak_q <= '0;
			rpeak_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.acc_en) begin
			if (cnt_full) begin
				ovf_q <= 1'b1;
			end else begin
				lsum_q <= lsum_q + SUM_W'(lsq);
				rsum_q <= rsum_q + SUM_W'(rsq);
				if (lmag > lpeak_q) begin
					lpeak_q <= lmag;
				end
				if (rmag > rpeak_q) begin
					rpeak_q <= rmag;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// ---------------- restoring divider, both lanes share the divisor ----------------
	logic [SUM_W-1:0]   lquo_q, rquo_q;
	logic [CNT_W-1:0]   lrem_q, rrem_q;
	logic [DSTEP_W-1:0] dstep_q;
	logic [CNT_W:0]     ltrial, rtrial, divisor;
	logic               lfit, rfit;

	assign divisor = {1'b0, cnt_q};
	assign ltrial  = {lrem_q, lquo_q[SUM_W-1]};
	assign rtrial  = {rrem_q, rquo_q[SUM_W-1]};
	assign lfit    = (ltrial >= divisor);
	assign rfit    = (rtrial >= divisor);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			lquo_q  <= lsum_q;
			rquo_q  <= rsum_q;
			lrem_q  <= '0;
			rrem_q  <= '0;
			dstep_q <= '0;
		end else if (cmd.div_step) begin
			lquo_q  <= {lquo_q[SUM_W-2:0], lfit};
			rquo_q  <= {rquo_q[SUM_W-2:0], rfit};
			lrem_q  <= lfit ? CNT_W'(ltrial - divisor) : CNT_W'(ltrial);
			rrem_q  <= rfit ? CNT_W'(rtrial - divisor) : CNT_W'(rtrial);
			dstep_q <= dstep_q + DSTEP_W'(1);
		end
	end

	assign sts.div_last = (dstep_q == DSTEP_W'(SUM_W - 1));

	// ---------------- bit-serial isqrt, two radicand bits per step ----------------
	// quotient is a mean square, at most 2^30, so it fits the radicand
	logic [RAD_W-1:0]   lrad_q, rrad_q;
	logic [REM_W-1:0]   lsrem_q, rsrem_q;
	logic [MAG_W-1:0]   lroot_q, rroot_q;
	logic [SSTEP_W-1:0] sstep_q;
	logic [REM_W+1:0]   lsh, rsh, ltry, rtry;
	logic               lok, rok;

	assign lsh  = {lsrem_q, lrad_q[RAD_W-1 -: 2]};
	assign rsh  = {rsrem_q, rrad_q[RAD_W-1 -: 2]};
	assign ltry = {1'b0, lroot_q, 2'b01};
	assign rtry = {1'b0, rroot_q, 2'b01};
	assign lok  = (lsh >= ltry);
	assign rok  = (rsh >= rtry);

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			lrad_q  <= RAD_W'(lquo_q);
			rrad_q  <= RAD_W'(rquo_q);
			lsrem_q <= '0;
			rsrem_q <= '0;
			lroot_q <= '0;
			rroot_q <= '0;
			sstep_q <= '0;
		end else if (cmd.sq_step) begin
			lrad_q  <= {lrad_q[RAD_W-3:0], 2'b00};
			rrad_q  <= {rrad_q[RAD_W-3:0], 2'b00};
			lsrem_q <= lok ? REM_W'(lsh - ltry) : REM_W'(lsh);
			rsrem_q <= rok ? REM_W'(rsh - rtry) : REM_W'(rsh);
			lroot_q <= {lroot_q[MAG_W-2:0], lok};
			rroot_q <= {rroot_q[MAG_W-2:0], rok};
			sstep_q <= sstep_q + SSTEP_W'(1);
		end
	end

	assign sts.sq_last = (sstep_q == SSTEP_W'(sprlm_pkg::SQ_STEPS - 1));

	// ---------------- result register ----------------
	logic [MAG_W-1:0]        llev, rlev, pk;
	logic [MAG_W:0]          lev_sum;
	logic [CNT_W+FCNT_W-1:0] cnt_ext;
	sprlm_pkg::out_beat_t    out_q;

	assign llev    = (lroot_q > lpeak_q) ? lroot_q : lpeak_q;
	assign rlev    = (rroot_q > rpeak_q) ? rroot_q : rpeak_q;
	assign pk      = (lpeak_q > rpeak_q) ? lpeak_q : rpeak_q;
	assign lev_sum = {1'b0, llev} + {1'b0, rlev};
	assign cnt_ext = (CNT_W + FCNT_W)'(cnt_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.l_lvl          <= llev;
			out_q.r_lvl          <= rlev;
			out_q.overall_peak   <= pk;
			out_q.mean_level     <= lev_sum[MAG_W:1];
			out_q.frames_counted <= cnt_ext[FCNT_W-1:0];
			out_q.block_overflow <= ovf_q;
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

/* rtl/stereo_peak_rms_level_meter.sv */
// Top level of the stereo peak/RMS level meter: register port, controller, datapath.
// Usage:
//  - Input channel (in_valid/in_stall/in_data): one stereo frame per beat. Frames are
//    taken one per cycle while the meter is accumulating.
//  - A beat with last_in_block closes the block. The meter then stalls its input while
//    a shared-divisor restoring divider (one quotient bit per cycle, over the SUM_W-bit
//    sum, SUM_W = clog2(MAX_FRAMES)+31, 43 at the default) and a 16-bit bit-serial isqrt run.
//  - Output channel (out_valid/out_stall/out_data): one result beat per block, held in a
//    result register. The next block is accumulated while that result waits; only the
//    final load of a further result waits for the receiver to take the previous one.
//  - Frames past MAX_FRAMES in a block are dropped and flag block_overflow.
//  - Register stereo_mode at byte address 0 (reset 1); 0 copies left into right.
//    Write it only while the meter is idle.
//  - Reset (arst_n low) clears all accumulators, the sequencer and the output valid;
//    stereo_mode returns to 1.
`default_nettype none
module stereo_peak_rms_level_meter #(
	parameter int MAX_FRAMES = 4096
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// frame input
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire sprlm_pkg::in_beat_t                    in_data,
	// result output
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output sprlm_pkg::out_beat_t                        out_data,
	// register port
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [sprlm_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire logic [sprlm_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [sprlm_pkg::APB_DATA_W-1:0]            prdata,
	output logic                                        pready
);

	// ---- register file: a single mode bit ----
	logic                                 stereo_mode_q;
	logic [sprlm_pkg::REG_IDX_W-1:0]      reg_idx;
	logic                                 reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[sprlm_pkg::APB_ADDR_W-1 -: sprlm_pkg::REG_IDX_W];
	assign reg_wr  = psel && penable && pwrite && pready
		&& (reg_idx == sprlm_pkg::REG_STEREO_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_mode_q <= 1'b1;
		end else if (reg_wr) begin
			stereo_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == sprlm_pkg::REG_STEREO_MODE) begin
			prdata[0] = stereo_mode_q;
		end
	end

	// ---- controller and datapath ----
	sprlm_pkg::ctrl_cmd_t cmd;
	sprlm_pkg::ctrl_sts_t sts;

	sprlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.last_in_block),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	sprlm_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stereo_mode (stereo_mode_q),
		.in_data     (in_data),
		.sts         (sts),
		.out_data    (out_data)
	);

`ifndef SYNTHESIS
	// closing a block must hold off the next frame while the result is computed
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.last_in_block |=> in_stall)
		else $error("frame taken right after the closing beat of a block");

	// mean lies between the two channel levels
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.mean_level <= out_data.l_lvl
			|| out_data.mean_level <= out_data.r_lvl)
			&& (out_data.mean_level >= out_data.l_lvl
			|| out_data.mean_level >= out_data.r_lvl))
		else $error("mean_level outside the channel levels");

	// overflow only once the block is full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.block_overflow
			|-> out_data.frames_counted == sprlm_pkg::FCNT_W'(MAX_FRAMES))
		else $error("overflow flagged on a block that is not full");

	// overall peak never exceeds the larger channel level
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.overall_peak <= out_data.l_lvl
			|| out_data.overall_peak <= out_data.r_lvl)
		else $error("overall_peak above both channel levels");
`endif

endmodule
`default_nettype wire

/* tb/stereo_peak_rms_level_meter_test.sv */
// Self-checking testbench for the stereo peak/RMS level meter: directed and random.
`timescale 1ns / 1ps
module stereo_peak_rms_level_meter_test;

	localparam int BLOCK_CAPACITY = 4096;
	localparam int SETTLE_CYCLES  = 80;      // margin past the divide + root tail
	localparam int CYCLE_LIMIT    = 500000;  // watchdog bound for the whole run
	localparam int RANDOM_FRAMES  = 560;
	localparam int PHASES         = 8;       // four idle mixes x two channel modes
	localparam logic [sprlm_pkg::REG_IDX_W-1:0]  REG_IDX_UNMAPPED = 1'b1;
	localparam logic [sprlm_pkg::APB_ADDR_W-1:0] ADDR_STEREO_MODE =
		{sprlm_pkg::REG_STEREO_MODE, 2'b00};
	localparam logic [sprlm_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED    = {REG_IDX_UNMAPPED, 2'b00};

	// sender idle / receiver stall percentages per idle mix
	localparam int SEND_IDLE[4] = '{0, 86, 0, 13};
	localparam int RECV_STALL[4] = '{0, 0, 86, 13};

	// sample content styles for random blocks
	typedef enum int {TONE_FULL, TONE_QUIET, TONE_EXTREME, TONE_FLAT} tone_t;

	logic                             clk;
	logic                             arst_n   = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	sprlm_pkg::in_beat_t              in_data  = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	sprlm_pkg::out_beat_t             out_data;
	logic                             psel    = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite  = 1'b0;
	logic [sprlm_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [sprlm_pkg::APB_DATA_W-1:0] pwdata  = '0;
	logic [sprlm_pkg::APB_DATA_W-1:0] prdata;
	logic                             pready;

	stereo_peak_rms_level_meter #(.MAX_FRAMES(BLOCK_CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// frames waiting for the driver, block results waiting for the monitor
	sprlm_pkg::in_beat_t  frame_queue[$];
	sprlm_pkg::out_beat_t expected_levels[$];

	// shadow of the meter: register plus per-block accumulators
	logic        stereo_on      = 1'b1;
	logic [42:0] left_sq_acc    = '0;
	logic [42:0] right_sq_acc   = '0;
	logic [15:0] l_pk_acc       = '0;
	logic [15:0] r_pk_acc       = '0;
	int          frames_held    = 0;
	logic        frames_dropped = 1'b0;

	int send_idle_pct   = 0;
	int out_stall_pct   = 0;
	int mismatch_count  = 0;
	int frames_accepted = 0;
	int results_checked = 0;
	int overflow_blocks = 0;
	int cycle_count     = 0;
	sprlm_pkg::out_beat_t got_want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// |s|; the most negative sample wraps to 0x8000 = 32768
	function automatic logic [15:0] sample_mag(input logic signed [15:0] s);
		int v;
		v = s;
		return 16'((v < 0) ? -v : v);
	endfunction

	// floor(sqrt(x)), one root bit at a time from the top
	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	// level = max(floor(sqrt(floor(sum / n))), peak)
	function automatic logic [15:0] channel_reading(input logic [42:0] acc, input int n,
			input logic [15:0] peak);
		longint unsigned rms;
		rms = (n == 0) ? 64'd0 : floor_root(64'(acc) / 64'(n));
		return (rms > 64'(peak)) ? 16'(rms) : peak;
	endfunction

	// fold one accepted frame into the shadow; a last frame closes the block
	task automatic meter_take(input sprlm_pkg::in_beat_t f);
		logic [15:0]          lm, rm;
		logic [16:0]          pair;
		sprlm_pkg::out_beat_t r;
		lm = sample_mag(f.l_smp);
		rm = stereo_on ? sample_mag(f.r_smp) : lm;
		if (frames_held < BLOCK_CAPACITY) begin
			left_sq_acc  = left_sq_acc + 43'(lm) * 43'(lm);
			right_sq_acc = right_sq_acc + 43'(rm) * 43'(rm);
			if (lm > l_pk_acc) l_pk_acc = lm;
			if (rm > r_pk_acc) r_pk_acc = rm;
			frames_held++;
		end else begin
			// block full: frame dropped, only the flag remembers it
			frames_dropped = 1'b1;
		end
		if (f.last_in_block) begin
			r.l_lvl          = channel_reading(left_sq_acc, frames_held, l_pk_acc);
			r.r_lvl          = channel_reading(right_sq_acc, frames_held, r_pk_acc);
			r.overall_peak   = (l_pk_acc > r_pk_acc) ? l_pk_acc : r_pk_acc;
			pair             = {1'b0, r.l_lvl} + {1'b0, r.r_lvl};
			r.mean_level     = pair[16:1];
			r.frames_counted = frames_held[sprlm_pkg::FCNT_W-1:0];
			r.block_overflow = frames_dropped;
			expected_levels.push_back(r);
			left_sq_acc    = '0;
			right_sq_acc   = '0;
			l_pk_acc       = '0;
			r_pk_acc       = '0;
			frames_held    = 0;
			frames_dropped = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// APB write: setup cycle, access cycle, register takes it at the access edge
	task automatic reg_write(input logic [sprlm_pkg::APB_ADDR_W-1:0] addr,
			input logic [sprlm_pkg::APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// unmapped indexes leave the register alone
		if (addr[sprlm_pkg::APB_ADDR_W-1:2] == sprlm_pkg::REG_STEREO_MODE)
			stereo_on = data[0];
		@(negedge clk);
	endtask

	// APB read of stereo_mode, sampled at the access edge
	task automatic mode_readback();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_STEREO_MODE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("stereo_mode readback", {31'b0, stereo_on}, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_frame(input logic signed [15:0] l, input logic signed [15:0] r,
			input logic last);
		sprlm_pkg::in_beat_t f;
		f.l_smp         = l;
		f.r_smp         = r;
		f.last_in_block = last;
		frame_queue.push_back(f);
	endtask

	function automatic logic signed [15:0] pick_sample(input tone_t tone,
			input logic signed [15:0] flat);
		case (tone)
			TONE_QUIET: return 16'($urandom_range(64)) - 16'd32;
			TONE_EXTREME: begin
				case ($urandom_range(4))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					3: return 16'shFFFF;
					default: return 16'($urandom);
				endcase
			end
			TONE_FLAT: return flat;
			default: return 16'($urandom);
		endcase
	endfunction

	// one well-formed block of random content, last frame marked
	task automatic queue_block(input int len);
		tone_t              tone;
		logic signed [15:0] flat;
		tone = tone_t'($urandom_range(3));
		flat = 16'($urandom);
		for (int i = 0; i < len; i++)
			queue_frame(pick_sample(tone, flat), pick_sample(tone, ~flat), i == len - 1);
	endtask

	// wait until every frame is in and every result is out, then let the tail settle
	task automatic drain_meter();
		do @(negedge clk);
		while (frame_queue.size() != 0 || in_valid || expected_levels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// frame driver: predict on acceptance, hold a stalled beat, idle at random
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				meter_take(in_data);
				frames_accepted++;
			end
			if (in_valid && in_stall) begin
				// beat held as is
			end else if (frame_queue.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= frame_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor: random back-pressure, every taken beat checked in order
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_levels.size() == 0) begin
					$error("result beat with no block pending: %p", out_data);
					mismatch_count++;
				end else begin
					got_want = expected_levels.pop_front();
					check_field("left level", got_want.l_lvl, out_data.l_lvl);
					check_field("right level", got_want.r_lvl, out_data.r_lvl);
					check_field("overall_peak", got_want.overall_peak,
						out_data.overall_peak);
					check_field("mean_level", got_want.mean_level, out_data.mean_level);
					check_field("frames_counted", got_want.frames_counted,
						out_data.frames_counted);
					check_field("block_overflow", got_want.block_overflow,
						out_data.block_overflow);
					results_checked++;
					if (got_want.block_overflow) overflow_blocks++;
				end
			end
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_levels.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int                               phase_frames;
		int                               len;
		logic [sprlm_pkg::APB_DATA_W-1:0] wdata;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		mode_readback();   // reset value is stereo

		// stereo: extremes, most negative sample, alternating bit patterns
		queue_frame(16'sh8000, 16'sh7FFF, 1'b1);
		queue_frame(16'sh0000, 16'sh0000, 1'b1);
		queue_frame(16'sh7FFF, 16'sh8000, 1'b0);
		queue_frame(16'sh5555, 16'shAAAA, 1'b0);
		queue_frame(16'shFFFF, 16'sh0001, 1'b1);
		queue_frame(16'shAAAA, 16'sh5555, 1'b0);
		queue_frame(16'sh0001, 16'shFFFF, 1'b1);
		drain_meter();

		// mono through a write with junk upper bits; unmapped index must not disturb it
		reg_write(ADDR_STEREO_MODE, 32'hFFFF_FFFE);
		mode_readback();
		reg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
		mode_readback();
		queue_frame(16'sd100, 16'sh8000, 1'b0);
		queue_frame(16'sh8000, 16'sd5, 1'b0);
		queue_frame(16'sd7, 16'sh7FFF, 1'b1);
		queue_frame(16'shFFFF, 16'sh7FFF, 1'b1);
		drain_meter();

		// random blocks, mostly short, under every idle mix in both modes
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = SEND_IDLE[p / 2];
			out_stall_pct = RECV_STALL[p / 2];
			wdata         = $urandom;
			wdata[0]      = p[0];
			reg_write(ADDR_STEREO_MODE, wdata);
			reg_write(ADDR_UNMAPPED, $urandom);
			mode_readback();
			phase_frames = 0;
			while (phase_frames < RANDOM_FRAMES / PHASES) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(13, 60)
					: $urandom_range(1, 12);
				queue_block(len);
				phase_frames += len;
			end
			drain_meter();
		end

		$display("Level meter run: %0d frames in, %0d block results checked, %0d overflowed",
			frames_accepted, results_checked, overflow_blocks);
		$display("Covered stereo and mono, extreme and random samples, short and medium blocks,");
		$display("four idle/stall mixes");
		if (mismatch_count == 0 && expected_levels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
